>>> rtl/ems_pkg.sv
// shared types, codes and arithmetic helpers for the eigenpair magnitude sort
package ems_pkg;

   // request action codes
   typedef enum logic [2:0] {
      ACT_LOAD_VALUE  = 3'd0,
      ACT_LOAD_VECTOR = 3'd1,
      ACT_RUN_SORT    = 3'd2,
      ACT_READ_VALUE  = 3'd3,
      ACT_READ_VECTOR = 3'd4
   } action_type;

   // sort mode codes
   localparam logic [1:0] MODE_ASC  = 2'd1;
   localparam logic [1:0] MODE_DESC = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_SIZE_IN_USE     = 2'd0;
   localparam logic [1:0] CSR_SORT_MODE       = 2'd1;
   localparam logic [1:0] CSR_VECTORS_PRESENT = 2'd2;
   localparam logic [1:0] CSR_KEEP_PARITY     = 2'd3;

   // csr reset values
   localparam logic [3:0] RST_SIZE_IN_USE     = 4'd8;
   localparam logic [1:0] RST_SORT_MODE       = 2'd0;
   localparam logic       RST_VECTORS_PRESENT = 1'b1;
   localparam logic       RST_KEEP_PARITY     = 1'b0;

   typedef struct packed {
      logic [3:0] size_in_use;
      logic [1:0] sort_mode;
      logic       vectors_present;
      logic       keep_parity;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] read_data;
      logic        odd_swaps;
   } res_type;

   // absolute value, saturating for the most negative word
   function automatic logic [30:0] magnitude(input logic [31:0] w);
      logic [31:0] m;
      begin
         m = 32'd0 - w;
         if (!w[31]) begin
            magnitude = w[30:0];
         end else if (m[31]) begin
            magnitude = 31'h7FFF_FFFF;
         end else begin
            magnitude = m[30:0];
         end
      end
   endfunction

   // two's complement negate, saturating for the most negative word
   function automatic logic [31:0] negate_sat(input logic [31:0] w);
      begin
         if (w == 32'h8000_0000) begin
            negate_sat = 32'h7FFF_FFFF;
         end else begin
            negate_sat = 32'd0 - w;
         end
      end
   endfunction

endpackage

>>> rtl/ems_ram.sv
// generic single write, single read ram with registered read data
module ems_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ems_ctrl.sv
// sequencer: loads, reads and the selection sort over the value and vector rams
module ems_ctrl #(
   parameter int MAX_SIZE = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  ems_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_col,
   input  logic signed [31:0] req_datum,
   input  logic               out_free,
   output ems_pkg::res_type   res
);

   localparam int IW  = $clog2(MAX_SIZE);
   localparam int CW  = $clog2(MAX_SIZE + 1);
   localparam int VAW = $clog2(MAX_SIZE * MAX_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_DONE,
      ST_P_START, ST_P_FIRST, ST_P_SCAN, ST_P_DECIDE, ST_SW_B,
      ST_V_RA, ST_V_RB, ST_V_WA, ST_V_WB,
      ST_N_RD, ST_N_WR
   } st_type;

   function automatic logic [VAW-1:0] vaddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      begin
         vaddr = VAW'(r) * VAW'(MAX_SIZE) + VAW'(c);
      end
   endfunction

   st_type            state_ff, state_in;
   logic [IW-1:0]     i_ff, i_in, j_ff, j_in, best_ff, best_in, r_ff, r_in;
   logic [30:0]       best_mag_ff, best_mag_in;
   logic [31:0]       best_val_ff, best_val_in, val_i_ff, val_i_in, tmp_ff, tmp_in;
   logic              parity_ff, parity_in, rd_zero_ff, rd_zero_in, rd_vec_ff, rd_vec_in;
   logic [IW-1:0]     va_hold_ff, va_hold_in;
   logic [VAW-1:0]    vc_hold_ff, vc_hold_in;

   logic              val_we, vec_we;
   logic [IW-1:0]     val_waddr, val_raddr;
   logic [VAW-1:0]    vec_waddr, vec_raddr;
   logic [31:0]       val_wdata, val_rdata, vec_wdata, vec_rdata;

   logic [CW-1:0]     n_c;
   logic [IW-1:0]     last_idx;
   logic              row_ok, col_ok, sorting, asc, better, last_pass;
   logic [30:0]       cand_mag;
   logic [IW-1:0]     req_r, req_c;
   st_type            end_state, next_pass_state;
   ems_pkg::action_type act;

   ems_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   ems_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (vec_waddr),
      .wr_data (vec_wdata),
      .rd_addr (vec_raddr),
      .rd_data (vec_rdata)
   );

   always_comb begin
      n_c       = (32'(cfg.size_in_use) > MAX_SIZE) ? CW'(MAX_SIZE) : CW'(cfg.size_in_use);
      last_idx  = IW'(n_c - CW'(1));
      row_ok    = {29'd0, req_row} < 32'(MAX_SIZE);
      col_ok    = {29'd0, req_col} < 32'(MAX_SIZE);
      req_r     = IW'(req_row);
      req_c     = IW'(req_col);
      act       = ems_pkg::action_type'(req_action);
      asc       = (cfg.sort_mode == ems_pkg::MODE_ASC);
      sorting   = asc || (cfg.sort_mode == ems_pkg::MODE_DESC);
      cand_mag  = ems_pkg::magnitude(val_rdata);
      better    = asc ? (cand_mag < best_mag_ff) : (cand_mag > best_mag_ff);
      last_pass = ((i_ff + IW'(1)) == last_idx);
      end_state = (cfg.keep_parity && parity_ff && cfg.vectors_present) ? ST_N_RD : ST_DONE;
      next_pass_state = last_pass ? end_state : ST_P_START;
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      best_in     = best_ff;
      r_in        = r_ff;
      best_mag_in = best_mag_ff;
      best_val_in = best_val_ff;
      val_i_in    = val_i_ff;
      tmp_in      = tmp_ff;
      parity_in   = parity_ff;
      rd_zero_in  = rd_zero_ff;
      rd_vec_in   = rd_vec_ff;
      va_hold_in  = va_hold_ff;
      vc_hold_in  = vc_hold_ff;
      val_we      = 1'b0;
      val_waddr   = i_ff;
      val_wdata   = best_val_ff;
      val_raddr   = va_hold_ff;
      vec_we      = 1'b0;
      vec_waddr   = vaddr(r_ff, i_ff);
      vec_wdata   = vec_rdata;
      vec_raddr   = vc_hold_ff;
      req_ready   = 1'b0;
      res         = '0;
      res.odd_swaps = parity_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            va_hold_in = req_r;
            vc_hold_in = vaddr(req_r, req_c);
            val_raddr  = req_r;
            vec_raddr  = vaddr(req_r, req_c);
            val_waddr  = req_r;
            val_wdata  = req_datum;
            vec_waddr  = vaddr(req_r, req_c);
            vec_wdata  = req_datum;
            if (req_valid) begin
               unique case (act)
                  ems_pkg::ACT_LOAD_VALUE: begin
                     val_we = row_ok;
                  end
                  ems_pkg::ACT_LOAD_VECTOR: begin
                     vec_we = row_ok && col_ok;
                  end
                  ems_pkg::ACT_RUN_SORT: begin
                     parity_in = 1'b0;
                     i_in      = '0;
                     state_in  = (sorting && n_c > CW'(1)) ? ST_P_START : ST_DONE;
                  end
                  ems_pkg::ACT_READ_VALUE: begin
                     rd_zero_in = !row_ok;
                     rd_vec_in  = 1'b0;
                     state_in   = ST_RD;
                  end
                  ems_pkg::ACT_READ_VECTOR: begin
                     rd_zero_in = !(row_ok && col_ok);
                     rd_vec_in  = 1'b1;
                     state_in   = ST_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD: begin
            if (out_free) begin
               res.valid     = 1'b1;
               res.read_data = rd_zero_ff ? 32'd0 : (rd_vec_ff ? vec_rdata : val_rdata);
               state_in      = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res.valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_P_START: begin
            val_raddr = i_ff;
            state_in  = ST_P_FIRST;
         end
         ST_P_FIRST: begin
            val_raddr   = i_ff + IW'(1);
            best_in     = i_ff;
            best_mag_in = cand_mag;
            best_val_in = val_rdata;
            val_i_in    = val_rdata;
            j_in        = i_ff + IW'(1);
            state_in    = ST_P_SCAN;
         end
         ST_P_SCAN: begin
            val_raddr = j_ff + IW'(1);
            if (better) begin
               best_in     = j_ff;
               best_mag_in = cand_mag;
               best_val_in = val_rdata;
            end
            j_in = j_ff + IW'(1);
            if (j_ff == last_idx) begin
               state_in = ST_P_DECIDE;
            end
         end
         ST_P_DECIDE: begin
            if (best_ff == i_ff) begin
               i_in     = i_ff + IW'(1);
               state_in = next_pass_state;
            end else begin
               val_we    = 1'b1;
               val_waddr = i_ff;
               val_wdata = best_val_ff;
               parity_in = !parity_ff;
               state_in  = ST_SW_B;
            end
         end
         ST_SW_B: begin
            val_we    = 1'b1;
            val_waddr = best_ff;
            val_wdata = val_i_ff;
            r_in      = '0;
            if (cfg.vectors_present) begin
               state_in = ST_V_RA;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = next_pass_state;
            end
         end
         ST_V_RA: begin
            vec_raddr = vaddr(r_ff, i_ff);
            state_in  = ST_V_RB;
         end
         ST_V_RB: begin
            vec_raddr = vaddr(r_ff, best_ff);
            tmp_in    = vec_rdata;
            state_in  = ST_V_WA;
         end
         ST_V_WA: begin
            vec_we    = 1'b1;
            vec_waddr = vaddr(r_ff, i_ff);
            vec_wdata = vec_rdata;
            state_in  = ST_V_WB;
         end
         ST_V_WB: begin
            vec_we    = 1'b1;
            vec_waddr = vaddr(r_ff, best_ff);
            vec_wdata = tmp_ff;
            if (r_ff == last_idx) begin
               r_in     = '0;
               i_in     = i_ff + IW'(1);
               state_in = next_pass_state;
            end else begin
               r_in     = r_ff + IW'(1);
               state_in = ST_V_RA;
            end
         end
         ST_N_RD: begin
            vec_raddr = vaddr(r_ff, '0);
            state_in  = ST_N_WR;
         end
         ST_N_WR: begin
            vec_we    = 1'b1;
            vec_waddr = vaddr(r_ff, '0);
            vec_wdata = ems_pkg::negate_sat(vec_rdata);
            r_in      = r_ff + IW'(1);
            state_in  = (r_ff == last_idx) ? ST_DONE : ST_N_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         parity_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         parity_ff <= parity_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      best_ff     <= best_in;
      r_ff        <= r_in;
      best_mag_ff <= best_mag_in;
      best_val_ff <= best_val_in;
      val_i_ff    <= val_i_in;
      tmp_ff      <= tmp_in;
      rd_zero_ff  <= rd_zero_in;
      rd_vec_ff   <= rd_vec_in;
      va_hold_ff  <= va_hold_in;
      vc_hold_ff  <= vc_hold_in;
   end

   // vector ram only moves during a run when columns follow the values
   a_vec_write_gated: assert property (@(posedge clock) disable iff (reset)
      (vec_we && state_ff != ST_IDLE) |-> cfg.vectors_present)
      else $error("vector store written during a run without vectors present");

   // a result is only offered when the output register can take it
   a_res_has_room: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> out_free)
      else $error("result offered while output register is full");

   // the scan index stays ahead of the pass index and inside the used size
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_SCAN) |-> (j_ff > i_ff && CW'(j_ff) < n_c))
      else $error("scan index out of range");

   // the negation pass only follows an odd exchange count with parity keeping on
   a_negate_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_N_RD) |-> (parity_ff && cfg.keep_parity))
      else $error("column negation without odd parity");

   // the chosen entry never lies before the slot being filled
   a_best_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_DECIDE) |-> (best_ff >= i_ff))
      else $error("selected entry precedes the current slot");

endmodule

>>> rtl/eigenpair_magnitude_sort.sv
// top level of the eigenpair magnitude sort: csr bank, sequencer and result register
//
// Holds up to MAX_SIZE signed Q15.16 eigenvalues in a small value ram and a
// MAX_SIZE x MAX_SIZE eigenvector store in a second ram (column c pairs with
// value c). Load beats (actions 0 and 1) are taken one per cycle while the
// block is idle and make no response. A read beat (actions 3 and 4) holds the
// block until its response goes out and returns the stored word, or zero for
// an index at or beyond MAX_SIZE. A run beat (action 2) selection-sorts the
// first n values by magnitude (n is size_in_use capped at MAX_SIZE) and
// returns one zero-data response carrying odd_swaps. Both rams have a single
// read port with registered read data. Each of the n-1 passes scans the
// magnitudes and decides; if a later entry wins, it exchanges the values and,
// when vectors are present, the columns. An optional column 0 negation
// follows the passes, and last the response is handed out. Further request
// beats are held off until the run finishes. The response sits in an output
// register, so loads keep flowing while a response waits to be taken.
// The most negative value has magnitude 0x7FFFFFFF and ties with the largest
// positive value; ties keep the earlier entry. CSR writes are only expected
// while idle.
module eigenpair_magnitude_sort #(
   parameter int MAX_SIZE = 8
) (
   input  logic               clock,
   input  logic               reset,
   // csr write port
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [3:0]         csr_wdata,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_col,
   input  logic signed [31:0] req_datum,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_data,
   output logic               rsp_odd_swaps
);

   ems_pkg::cfg_type cfg_ff, cfg_in;
   ems_pkg::res_type res;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_odd_ff, rsp_odd_in;
   logic             out_free;

   // csr bank, fields masked to their widths
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ems_pkg::CSR_SIZE_IN_USE:     cfg_in.size_in_use     = csr_wdata;
            ems_pkg::CSR_SORT_MODE:       cfg_in.sort_mode       = csr_wdata[1:0];
            ems_pkg::CSR_VECTORS_PRESENT: cfg_in.vectors_present = csr_wdata[0];
            ems_pkg::CSR_KEEP_PARITY:     cfg_in.keep_parity     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // output register frees when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   ems_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_datum  (req_datum),
      .out_free   (out_free),
      .res        (res)
   );

   // response beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_odd_in   = rsp_odd_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.read_data;
         rsp_odd_in   = res.odd_swaps;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_in_use     <= ems_pkg::RST_SIZE_IN_USE;
         cfg_ff.sort_mode       <= ems_pkg::RST_SORT_MODE;
         cfg_ff.vectors_present <= ems_pkg::RST_VECTORS_PRESENT;
         cfg_ff.keep_parity     <= ems_pkg::RST_KEEP_PARITY;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_odd_ff  <= rsp_odd_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_odd_swaps = rsp_odd_ff;

   // a waiting response is never overwritten before it is taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)
                                        && $stable(rsp_odd_ff)))
      else $error("pending response overwritten");

   // a run or read request is never taken while the block is busy
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ems_pkg::ACT_RUN_SORT
                                  || req_action == ems_pkg::ACT_READ_VALUE
                                  || req_action == ems_pkg::ACT_READ_VECTOR))
      |=> !req_ready)
      else $error("request taken while previous work pending");

   // a response beat only appears after the sequencer produced one
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res.valid))
      else $error("response appeared without a result");

endmodule
